[sv/cbfm_pkg.sv]
// ----------------------------------------------------------------------------
// cbfm_pkg
// Shared types and constants for the capture black/frozen monitor.
// ----------------------------------------------------------------------------
package cbfm_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned TsW    = 48;
  localparam int unsigned MediaW = 32;
  localparam int unsigned PrintW = 64;
  localparam int unsigned TolW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Packed input item: black, fingerprint, timestamp, active, mvalid, media
  localparam int unsigned InFieldsW = 1 + PrintW + TsW + 1 + 1 + MediaW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = 8;

  localparam logic [CntW-1:0] CntMax = '1;

  // register reset values
  localparam logic [CntW-1:0]   MinObsRst      = 16'd3;
  localparam logic [31:0]       BlackThrRst    = 32'd2000;
  localparam logic [31:0]       FrozenThrRst   = 32'd2000;
  localparam logic [31:0]       BlackAdvRst    = 32'd1000;
  localparam logic [31:0]       FrozenAdvRst   = 32'd1000;
  localparam logic [TolW-1:0]   RewindTolRst   = 16'd250;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_OBS    = 3'd0,
    REG_BLACK_THR  = 3'd1,
    REG_FROZEN_THR = 3'd2,
    REG_BLACK_ADV  = 3'd3,
    REG_FROZEN_ADV = 3'd4,
    REG_REWIND_TOL = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HEALTH_OK     = 2'd0,
    HEALTH_BLACK  = 2'd1,
    HEALTH_FROZEN = 2'd2
  } health_e;

  // one run as seen by the due check
  typedef struct packed {
    logic [CntW-1:0]   count;
    logic [TsW-1:0]    start_ms;
    logic [MediaW-1:0] media_start;
  } run_t;

  // run limits taken from configuration
  typedef struct packed {
    logic [31:0] threshold_ms;
    logic [31:0] advance_ms;
  } run_lim_t;

endpackage

[sv/cbfm_run_check.sv]
// ----------------------------------------------------------------------------
// cbfm_run_check
// Decides whether one run is long enough, old enough and has seen enough
// media advance to be reported.
// ----------------------------------------------------------------------------
module cbfm_run_check (
  input  cbfm_pkg::run_t                  run_i,
  input  cbfm_pkg::run_lim_t              lim_i,
  input  logic [cbfm_pkg::CntW-1:0]       min_obs_i,
  input  logic [cbfm_pkg::TsW-1:0]        now_ms_i,
  input  logic                            media_valid_i,
  input  logic [cbfm_pkg::MediaW-1:0]     media_ms_i,
  output logic                            due_o
);

  logic [cbfm_pkg::TsW-1:0]  elapsed;
  logic [cbfm_pkg::MediaW:0] media_goal;
  logic count_ok, time_ok, media_ok;

  assign elapsed    = now_ms_i - run_i.start_ms;
  assign media_goal = {1'b0, run_i.media_start} + {1'b0, lim_i.advance_ms};

  assign count_ok = run_i.count >= min_obs_i;
  // a start in the future (timestamp went back) never reports
  assign time_ok  = (now_ms_i >= run_i.start_ms) &&
                    (elapsed >= {{(cbfm_pkg::TsW-32){1'b0}}, lim_i.threshold_ms});
  assign media_ok = media_valid_i && ({1'b0, media_ms_i} >= media_goal);

  assign due_o = count_ok && time_ok && media_ok;

endmodule

[sv/capture_black_frozen_monitor_core.sv]
// ----------------------------------------------------------------------------
// capture_black_frozen_monitor_core
// Per-frame capture health monitor: tracks black and frozen runs and reports
// healthy, continuously black or continuously frozen for every observation.
// ----------------------------------------------------------------------------
// One observation enters per captured frame and one health item leaves for
// each, in order. An item is captured in an input register, evaluated against
// the run state and written to an output register together with the run state
// update, so the block sustains one item per clock while the output is not
// back-pressured. Back-pressure on the output stalls the evaluation stage only
// while the output register is still full. The first observation after reset
// merely seeds the run state and reports healthy. Configuration is taken at
// any time (cfg_ready_o is always high) and must only be changed while no item
// is in flight; indexes 6 and 7 are ignored.
// Input tdata layout, lowest bit first: black [0], fingerprint [64:1],
// wall-clock ms [112:65], play flag [113], media_time_valid [114],
// media_time_ms [146:115], zero padding up to bit 151. Output tdata carries
// health in [1:0] (0 healthy, 1 black, 2 frozen), upper bits zero.
// ----------------------------------------------------------------------------
module capture_black_frozen_monitor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // observation stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // black, fingerprint, wall-clock ms, play flag, media_time_valid,
  // media_time_ms, zero padding
  input  logic [cbfm_pkg::InDataW-1:0]        s_axis_tdata,
  // health stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // health, zero padding
  output logic [cbfm_pkg::OutDataW-1:0]       m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbfm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cbfm_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned CntW   = cbfm_pkg::CntW;
  localparam int unsigned TsW    = cbfm_pkg::TsW;
  localparam int unsigned MediaW = cbfm_pkg::MediaW;
  localparam int unsigned PrintW = cbfm_pkg::PrintW;
  localparam int unsigned TolW   = cbfm_pkg::TolW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CntW-1:0] min_obs_q;
  logic [31:0]     black_thr_q, frozen_thr_q, black_adv_q, frozen_adv_q;
  logic [TolW-1:0] rewind_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_obs_q    <= cbfm_pkg::MinObsRst;
      black_thr_q  <= cbfm_pkg::BlackThrRst;
      frozen_thr_q <= cbfm_pkg::FrozenThrRst;
      black_adv_q  <= cbfm_pkg::BlackAdvRst;
      frozen_adv_q <= cbfm_pkg::FrozenAdvRst;
      rewind_tol_q <= cbfm_pkg::RewindTolRst;
    end else if (cfg_valid_i) begin
      unique case (cbfm_pkg::cfg_reg_e'(cfg_index_i))
        cbfm_pkg::REG_MIN_OBS:    min_obs_q    <= cfg_data_i[CntW-1:0];
        cbfm_pkg::REG_BLACK_THR:  black_thr_q  <= cfg_data_i;
        cbfm_pkg::REG_FROZEN_THR: frozen_thr_q <= cfg_data_i;
        cbfm_pkg::REG_BLACK_ADV:  black_adv_q  <= cfg_data_i;
        cbfm_pkg::REG_FROZEN_ADV: frozen_adv_q <= cfg_data_i;
        cbfm_pkg::REG_REWIND_TOL: rewind_tol_q <= cfg_data_i[TolW-1:0];
        default: ;  // unused indexes: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              in_valid_q;
  logic              black_q, active_q, mvalid_q;
  logic [PrintW-1:0] print_q;
  logic [TsW-1:0]    now_q;
  logic [MediaW-1:0] media_q;

  logic out_valid_q;
  logic [1:0] health_q;
  logic advance;

  // evaluation stage moves when it holds an item and the output can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      black_q  <= s_axis_tdata[0];
      print_q  <= s_axis_tdata[PrintW:1];
      now_q    <= s_axis_tdata[PrintW+TsW:PrintW+1];
      active_q <= s_axis_tdata[PrintW+TsW+1];
      mvalid_q <= s_axis_tdata[PrintW+TsW+2];
      media_q  <= s_axis_tdata[PrintW+TsW+MediaW+2:PrintW+TsW+3];
    end
  end

  // --------------------------------------------------------------------------
  // Run state
  // --------------------------------------------------------------------------
  logic              started_q, started_d;
  logic              last_black_q, last_black_d;
  logic              last_pos_q, last_pos_d;
  logic [PrintW-1:0] last_print_q, last_print_d;
  cbfm_pkg::run_t    black_q_run, black_d_run;
  cbfm_pkg::run_t    frozen_q_run, frozen_d_run;

  logic            pos, play_start, act_blk, blk_rewind, frz_rewind;
  logic [MediaW:0] back;

  assign pos        = active_q && mvalid_q;
  assign act_blk    = black_q && pos;
  assign play_start = pos && !last_pos_q;
  // rewind: media + tolerance below the run's media start, 33-bit safe
  assign back       = {1'b0, media_q} + {{(MediaW+1-TolW){1'b0}}, rewind_tol_q};
  assign blk_rewind = pos && (back < {1'b0, black_q_run.media_start});
  assign frz_rewind = pos && (back < {1'b0, frozen_q_run.media_start});

  always_comb begin
    started_d    = 1'b1;
    last_black_d = act_blk;
    last_pos_d   = pos;
    last_print_d = last_print_q;
    black_d_run  = black_q_run;
    frozen_d_run = frozen_q_run;

    if (!started_q) begin
      // first observation seeds the runs
      last_print_d             = print_q;
      black_d_run.start_ms     = now_q;
      black_d_run.count        = act_blk ? CntW'(1) : '0;
      black_d_run.media_start  = act_blk ? media_q : '0;
      frozen_d_run.start_ms    = now_q;
      frozen_d_run.count       = pos ? CntW'(1) : '0;
      frozen_d_run.media_start = pos ? media_q : '0;
    end else begin
      // black run
      if (act_blk) begin
        if (!last_black_q || play_start || blk_rewind) begin
          black_d_run.start_ms    = now_q;
          black_d_run.count       = CntW'(1);
          black_d_run.media_start = media_q;
        end else if (black_q_run.count != cbfm_pkg::CntMax) begin
          black_d_run.count = black_q_run.count + CntW'(1);
        end
      end else begin
        // media start of the black run is deliberately kept
        black_d_run.start_ms = now_q;
        black_d_run.count    = '0;
      end

      // frozen run
      if (!pos || play_start || frz_rewind || (print_q != last_print_q)) begin
        last_print_d             = print_q;
        frozen_d_run.start_ms    = now_q;
        frozen_d_run.count       = pos ? CntW'(1) : '0;
        frozen_d_run.media_start = pos ? media_q : '0;
      end else if (frozen_q_run.count != cbfm_pkg::CntMax) begin
        frozen_d_run.count = frozen_q_run.count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      last_black_q <= 1'b0;
      last_pos_q   <= 1'b0;
      last_print_q <= '0;
      black_q_run  <= '0;
      frozen_q_run <= '0;
    end else if (advance) begin
      started_q    <= started_d;
      last_black_q <= last_black_d;
      last_pos_q   <= last_pos_d;
      last_print_q <= last_print_d;
      black_q_run  <= black_d_run;
      frozen_q_run <= frozen_d_run;
    end
  end

  // --------------------------------------------------------------------------
  // Report decision, on the updated runs
  // --------------------------------------------------------------------------
  cbfm_pkg::run_lim_t black_lim, frozen_lim;
  logic black_due, frozen_due;
  cbfm_pkg::health_e health_d;

  assign black_lim  = '{threshold_ms: black_thr_q,  advance_ms: black_adv_q};
  assign frozen_lim = '{threshold_ms: frozen_thr_q, advance_ms: frozen_adv_q};

  cbfm_run_check u_black_check (
    .run_i         (black_d_run),
    .lim_i         (black_lim),
    .min_obs_i     (min_obs_q),
    .now_ms_i      (now_q),
    .media_valid_i (mvalid_q),
    .media_ms_i    (media_q),
    .due_o         (black_due)
  );

  cbfm_run_check u_frozen_check (
    .run_i         (frozen_d_run),
    .lim_i         (frozen_lim),
    .min_obs_i     (min_obs_q),
    .now_ms_i      (now_q),
    .media_valid_i (mvalid_q),
    .media_ms_i    (media_q),
    .due_o         (frozen_due)
  );

  // black wins over frozen; first observation is always healthy
  always_comb begin
    priority if (!started_q) begin
      health_d = cbfm_pkg::HEALTH_OK;
    end else if (black_due) begin
      health_d = cbfm_pkg::HEALTH_BLACK;
    end else if (frozen_due) begin
      health_d = cbfm_pkg::HEALTH_FROZEN;
    end else begin
      health_d = cbfm_pkg::HEALTH_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      health_q <= health_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cbfm_pkg::OutDataW-2){1'b0}}, health_q};

endmodule
